/* rtl/ews_pkg.sv */
// shared constants, codes and types of the excitation waveform sequencer
// used by ews_serial_mul, excitation_waveform_sequencer_core, ews_checker and tb_top; no dependencies

package ews_pkg;

  // timer tick rate of the system that feeds the beats
  localparam int unsigned TICK_RATE_HZ = 1000;

  // fixed point constants, q30 and q28 radians
  localparam logic [31:0] Q30_ONE     = 32'd1073741824;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [63:0] TWO_PI_Q28  = 64'd1686629713;

  // velocity scale: tick rate times two pi, q28
  localparam logic [63:0] VEL_SCALE = 64'(TICK_RATE_HZ) * TWO_PI_Q28;
  localparam int VSC_W = $clog2(VEL_SCALE + 64'd1);
  // width of the angular rate w = (phase_step * VEL_SCALE) >> 28
  localparam int W_W = 32 + VSC_W - 28;

  // shared serial multiplier: signed a by signed b, one bit of b per cycle
  localparam int MUL_AW    = W_W + 1;
  localparam int MUL_BW    = 33;
  localparam int MUL_PW    = MUL_AW + MUL_BW;
  localparam int MUL_CNT_W = $clog2(MUL_BW);

  // horner coefficients, q30
  localparam logic [31:0] HS_C0 = 32'd2959;
  localparam logic [31:0] HS_C1 = 32'd213044;
  localparam logic [31:0] HS_C2 = 32'd8947849;
  localparam logic [31:0] HS_C3 = 32'd178956971;
  localparam logic [31:0] HC_C0 = 32'd296;
  localparam logic [31:0] HC_C1 = 32'd26631;
  localparam logic [31:0] HC_C2 = 32'd1491308;
  localparam logic [31:0] HC_C3 = 32'd44739243;
  localparam logic [31:0] HC_C4 = 32'd536870912;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_EXCITE_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRE_HOLD_TICKS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_TICKS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POST_HOLD_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_TOTAL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_AMPLITUDE  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP      = 3'd7;

  typedef enum logic [1:0] {
    PH_PRE,
    PH_ACTIVE,
    PH_POST,
    PH_FIN
  } phase_code_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EVAL,
    ST_ISSUE,
    ST_WAIT,
    ST_DONE
  } state_e;

  // products of one sine tick, in issue order
  typedef enum logic [3:0] {
    OP_W,
    OP_TH,
    OP_T2,
    OP_HS1,
    OP_HS2,
    OP_HS3,
    OP_HS4,
    OP_SS,
    OP_HC1,
    OP_HC2,
    OP_HC3,
    OP_HC4,
    OP_CC,
    OP_POS,
    OP_VAMP,
    OP_VEL
  } op_e;

endpackage

/* rtl/excitation_waveform_sequencer_core.sv */
// excitation waveform sequencer, top level: tick handling, run sequencing and sine datapath
// depends on ews_pkg and ews_serial_mul

// One input beat is one timer tick; a tick with restart set latches the baseline position
// and starts a run of repeat_total cycles, each made of pre-hold, active and post-hold
// phases, and that tick already yields a result. Ticks before the first restart are
// swallowed with no output beat. A tick in step mode, in a hold phase or after the run
// has finished goes from acceptance through the load, evaluate and done states back to
// idle. An active tick in sine mode runs 16 products through one shared bit-serial
// multiplier, each in 33 steps between its issue and its write-back; that multiplier
// sets the rate. Sine and cosine come from Taylor series in q30 over a quarter-turn
// reduced phase, velocity from the cosine scaled by the tick rate and phase step,
// saturated to 32 bits signed. A finished result sits in an output register, so the
// next tick may be accepted while it waits. Configuration writes are taken only while
// no tick is being worked on. No memories, no clearing pass.

module excitation_waveform_sequencer_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tick channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            restart_i,
  input  logic signed [31:0]              baseline_position_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      phase_code_o,
  output logic [7:0]                      cycle_number_o,
  output logic signed [31:0]              target_position_o,
  output logic signed [31:0]              target_velocity_o,
  output logic                            finished_o,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ews_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [31:0]                     cfg_data_i
);

  // ---------------------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------------------

  // baseline plus a 34 bit offset, clipped to 32 bit signed
  function automatic logic [31:0] sat_add(logic [31:0] base, logic [33:0] off);
    logic [34:0] s;
    s = {{3{base[31]}}, base} + {off[33], off};
    if (!s[34] && (s[33:31] != 3'b000)) begin
      return 32'h7fff_ffff;
    end else if (s[34] && (s[33:31] != 3'b111)) begin
      return 32'h8000_0000;
    end
    return s[31:0];
  endfunction

  // constant that each horner step subtracts from
  function automatic logic [31:0] horner_coef(ews_pkg::op_e op);
    logic [31:0] c;
    c = '0;
    case (op)
      ews_pkg::OP_HS1: c = ews_pkg::HS_C1;
      ews_pkg::OP_HS2: c = ews_pkg::HS_C2;
      ews_pkg::OP_HS3: c = ews_pkg::HS_C3;
      ews_pkg::OP_HS4: c = ews_pkg::Q30_ONE;
      ews_pkg::OP_HC1: c = ews_pkg::HC_C1;
      ews_pkg::OP_HC2: c = ews_pkg::HC_C2;
      ews_pkg::OP_HC3: c = ews_pkg::HC_C3;
      ews_pkg::OP_HC4: c = ews_pkg::HC_C4;
      default:         c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [ews_pkg::MUL_AW-1:0] sext_a(logic [31:0] x);
    return {{(ews_pkg::MUL_AW - 32){x[31]}}, x};
  endfunction

  function automatic logic [ews_pkg::MUL_BW-1:0] sext_b(logic [31:0] x);
    return {x[31], x};
  endfunction

  // ---------------------------------------------------------------------------
  // declarations
  // ---------------------------------------------------------------------------

  // configuration
  logic        cfg_mode_q;
  logic [31:0] cfg_pre_q;
  logic [31:0] cfg_act_q;
  logic [31:0] cfg_post_q;
  logic [7:0]  cfg_repeat_q;
  logic [31:0] cfg_step_q;
  logic [31:0] cfg_amp_q;
  logic [31:0] cfg_pstep_q;
  logic        cfg_we;

  // run state
  logic        armed_q;
  logic [31:0] base_q;
  logic [31:0] tick_q;
  logic [7:0]  cycle_q;
  logic [31:0] acc_q;

  // cycle boundaries
  logic [32:0] end_act_q;
  logic [33:0] total_q;

  // control
  ews_pkg::state_e state_q, state_d;
  ews_pkg::op_e    op_q;
  logic            in_accept;
  logic            mul_start;
  logic            out_load;

  // tick evaluation
  logic                 ev_fin;
  logic                 ev_wrap;
  logic                 ev_sine;
  ews_pkg::phase_code_e ev_code;
  logic [31:0]          ev_acc_d;

  // sine datapath
  logic [29:0]           ph_lo_q;
  logic [1:0]            quad_q;
  logic [ews_pkg::W_W-1:0] w_q;
  logic [31:0]           th_q;
  logic [31:0]           t2_q;
  logic [31:0]           h_q;
  logic [31:0]           ss_q;
  logic [31:0]           s_q;
  logic [31:0]           c_q;
  logic [31:0]           m_q;
  logic                  vneg_q;

  // multiplier
  logic [ews_pkg::MUL_AW-1:0] mul_a;
  logic [ews_pkg::MUL_BW-1:0] mul_b;
  logic                       mul_done;
  logic [ews_pkg::MUL_PW-1:0] mul_prod;

  // write-back terms
  logic [31:0] wb_y;
  logic [31:0] wb_cc;
  logic        wb_neg;
  logic [63:0] wb_abs;
  logic        wb_big;
  logic [30:0] wb_mag;

  // result of the current tick
  ews_pkg::phase_code_e res_code_q;
  logic [7:0]           res_cyc_q;
  logic [31:0]          res_pos_q;
  logic [31:0]          res_vel_q;
  logic                 res_fin_q;

  // output register
  logic                 out_valid_q;
  ews_pkg::phase_code_e out_code_q;
  logic [7:0]           out_cyc_q;
  logic [31:0]          out_pos_q;
  logic [31:0]          out_vel_q;
  logic                 out_fin_q;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------

  assign cfg_we = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_mode_q   <= 1'b0;
      cfg_pre_q    <= 32'd2000;
      cfg_act_q    <= 32'd1000;
      cfg_post_q   <= 32'd2000;
      cfg_repeat_q <= 8'd3;
      cfg_step_q   <= 32'd671089;
      cfg_amp_q    <= 32'd536871;
      cfg_pstep_q  <= 32'd4294967;
    end else if (cfg_we) begin
      case (cfg_index_i)
        ews_pkg::CFG_EXCITE_MODE:     cfg_mode_q   <= cfg_data_i[0];
        ews_pkg::CFG_PRE_HOLD_TICKS:  cfg_pre_q    <= cfg_data_i;
        ews_pkg::CFG_ACTIVE_TICKS:    cfg_act_q    <= cfg_data_i;
        ews_pkg::CFG_POST_HOLD_TICKS: cfg_post_q   <= cfg_data_i;
        ews_pkg::CFG_REPEAT_TOTAL:    cfg_repeat_q <= cfg_data_i[7:0];
        ews_pkg::CFG_STEP_SIZE:       cfg_step_q   <= cfg_data_i;
        ews_pkg::CFG_WAVE_AMPLITUDE:  cfg_amp_q    <= cfg_data_i;
        ews_pkg::CFG_PHASE_STEP:      cfg_pstep_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------------

  always_comb begin
    state_d = state_q;
    case (state_q)
      ews_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = ews_pkg::ST_LOAD;
      end
      ews_pkg::ST_LOAD: begin
        // ticks before the first restart are dropped here
        state_d = armed_q ? ews_pkg::ST_EVAL : ews_pkg::ST_IDLE;
      end
      ews_pkg::ST_EVAL: begin
        state_d = ev_sine ? ews_pkg::ST_ISSUE : ews_pkg::ST_DONE;
      end
      ews_pkg::ST_ISSUE: begin
        state_d = ews_pkg::ST_WAIT;
      end
      ews_pkg::ST_WAIT: begin
        if (mul_done) begin
          state_d = (op_q == ews_pkg::OP_VEL) ? ews_pkg::ST_DONE : ews_pkg::ST_ISSUE;
        end
      end
      ews_pkg::ST_DONE: begin
        if (out_load) state_d = ews_pkg::ST_IDLE;
      end
      default: state_d = ews_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer: outputs
  // ---------------------------------------------------------------------------

  always_comb begin
    in_stall_o  = (state_q != ews_pkg::ST_IDLE);
    cfg_ready_o = (state_q == ews_pkg::ST_IDLE);
    in_accept   = in_valid_i && (state_q == ews_pkg::ST_IDLE);
    mul_start   = (state_q == ews_pkg::ST_ISSUE);
    // move the result on once the output register is free or being emptied
    out_load    = (state_q == ews_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ews_pkg::ST_IDLE;
      op_q    <= ews_pkg::OP_W;
    end else begin
      state_q <= state_d;
      if (state_q == ews_pkg::ST_EVAL) begin
        op_q <= ews_pkg::OP_W;
      end else if ((state_q == ews_pkg::ST_WAIT) && mul_done) begin
        op_q <= ews_pkg::op_e'(4'(op_q) + 4'd1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tick evaluation
  // ---------------------------------------------------------------------------

  always_comb begin
    ev_fin  = (cycle_q >= cfg_repeat_q);
    ev_wrap = (({2'b00, tick_q} + 34'd1) >= total_q);
    if (tick_q < cfg_pre_q) begin
      ev_code = ews_pkg::PH_PRE;
    end else if ({1'b0, tick_q} < end_act_q) begin
      ev_code = ews_pkg::PH_ACTIVE;
    end else begin
      ev_code = ews_pkg::PH_POST;
    end
    ev_sine = !ev_fin && (ev_code == ews_pkg::PH_ACTIVE) && cfg_mode_q;
    // phase clears off the active phase and at every cycle end
    if (ev_wrap || (ev_code != ews_pkg::PH_ACTIVE)) begin
      ev_acc_d = '0;
    end else begin
      ev_acc_d = acc_q + cfg_pstep_q;
    end
  end

  // run state: restart is applied at the accepting edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      base_q  <= '0;
      tick_q  <= '0;
      cycle_q <= '0;
      acc_q   <= '0;
    end else if (in_accept && restart_i) begin
      armed_q <= 1'b1;
      base_q  <= baseline_position_i;
      tick_q  <= '0;
      cycle_q <= '0;
      acc_q   <= '0;
    end else if ((state_q == ews_pkg::ST_EVAL) && !ev_fin) begin
      acc_q <= ev_acc_d;
      if (ev_wrap) begin
        tick_q  <= '0;
        cycle_q <= cycle_q + 8'd1;
      end else begin
        tick_q  <= tick_q + 32'd1;
      end
    end
  end

  // phase boundaries of the cycle
  always_ff @(posedge clk_i) begin
    if (state_q == ews_pkg::ST_LOAD) begin
      end_act_q <= {1'b0, cfg_pre_q} + {1'b0, cfg_act_q};
      total_q   <= {2'b00, cfg_pre_q} + {2'b00, cfg_act_q} + {2'b00, cfg_post_q};
    end
  end

  // ---------------------------------------------------------------------------
  // multiplier operands
  // ---------------------------------------------------------------------------

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_q)
      ews_pkg::OP_W: begin
        mul_a = ews_pkg::MUL_AW'(ews_pkg::VEL_SCALE);
        mul_b = {1'b0, cfg_pstep_q};
      end
      ews_pkg::OP_TH: begin
        // residual angle: phase minus nearest quarter turn, turns / 2^32
        mul_a = sext_a({{2{ph_lo_q[29]}}, ph_lo_q});
        mul_b = {1'b0, ews_pkg::HALF_PI_Q30};
      end
      ews_pkg::OP_T2: begin
        mul_a = sext_a(th_q);
        mul_b = sext_b(th_q);
      end
      ews_pkg::OP_HS1: begin
        mul_a = sext_a(t2_q);
        mul_b = sext_b(ews_pkg::HS_C0);
      end
      ews_pkg::OP_HC1: begin
        mul_a = sext_a(t2_q);
        mul_b = sext_b(ews_pkg::HC_C0);
      end
      ews_pkg::OP_HS2, ews_pkg::OP_HS3, ews_pkg::OP_HS4,
      ews_pkg::OP_HC2, ews_pkg::OP_HC3, ews_pkg::OP_HC4,
      ews_pkg::OP_CC: begin
        mul_a = sext_a(t2_q);
        mul_b = sext_b(h_q);
      end
      ews_pkg::OP_SS: begin
        mul_a = sext_a(th_q);
        mul_b = sext_b(h_q);
      end
      ews_pkg::OP_POS: begin
        mul_a = sext_a(cfg_amp_q);
        mul_b = sext_b(s_q);
      end
      ews_pkg::OP_VAMP: begin
        mul_a = sext_a(cfg_amp_q);
        mul_b = sext_b(c_q);
      end
      ews_pkg::OP_VEL: begin
        mul_a = {1'b0, w_q};
        mul_b = {1'b0, m_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ews_serial_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // ---------------------------------------------------------------------------
  // write-back
  // ---------------------------------------------------------------------------

  always_comb begin
    // q30 product, floored
    wb_y   = mul_prod[61:30];
    wb_cc  = ews_pkg::Q30_ONE - wb_y;
    wb_neg = mul_prod[ews_pkg::MUL_PW-1];
    wb_abs = wb_neg ? (64'd0 - mul_prod[63:0]) : mul_prod[63:0];
    // velocity magnitude saturates to 2^31 when negative and to 2^31 - 1 when positive
    wb_big = |mul_prod[ews_pkg::MUL_PW-1:67];
    wb_mag = mul_prod[66:36];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ews_pkg::ST_EVAL) begin
      ph_lo_q   <= acc_q[29:0];
      quad_q    <= acc_q[31:30] + {1'b0, acc_q[29]};
      res_code_q <= ev_fin ? ews_pkg::PH_FIN : ev_code;
      res_cyc_q  <= ev_fin ? cfg_repeat_q : (cycle_q + 8'd1);
      res_fin_q  <= ev_fin;
      res_vel_q  <= '0;
      if (!ev_fin && (ev_code == ews_pkg::PH_ACTIVE) && !cfg_mode_q) begin
        res_pos_q <= sat_add(base_q, {{2{cfg_step_q[31]}}, cfg_step_q});
      end else begin
        res_pos_q <= base_q;
      end
    end else if ((state_q == ews_pkg::ST_WAIT) && mul_done) begin
      case (op_q)
        ews_pkg::OP_W:  w_q  <= mul_prod[28 +: ews_pkg::W_W];
        ews_pkg::OP_TH: th_q <= wb_y;
        ews_pkg::OP_T2: t2_q <= wb_y;
        ews_pkg::OP_HS1, ews_pkg::OP_HS2, ews_pkg::OP_HS3, ews_pkg::OP_HS4,
        ews_pkg::OP_HC1, ews_pkg::OP_HC2, ews_pkg::OP_HC3, ews_pkg::OP_HC4: begin
          h_q <= horner_coef(op_q) - wb_y;
        end
        ews_pkg::OP_SS: ss_q <= wb_y;
        ews_pkg::OP_CC: begin
          // rotate back by the quarter turns taken off
          case (quad_q)
            2'd0: begin
              s_q <= ss_q;
              c_q <= wb_cc;
            end
            2'd1: begin
              s_q <= wb_cc;
              c_q <= 32'd0 - ss_q;
            end
            2'd2: begin
              s_q <= 32'd0 - ss_q;
              c_q <= 32'd0 - wb_cc;
            end
            default: begin
              s_q <= 32'd0 - wb_cc;
              c_q <= ss_q;
            end
          endcase
        end
        ews_pkg::OP_POS: res_pos_q <= sat_add(base_q, mul_prod[63:30]);
        ews_pkg::OP_VAMP: begin
          vneg_q <= wb_neg;
          m_q    <= wb_abs[61:30];
        end
        ews_pkg::OP_VEL: begin
          if (vneg_q) begin
            res_vel_q <= wb_big ? 32'h8000_0000 : (32'd0 - {1'b0, wb_mag});
          end else begin
            res_vel_q <= wb_big ? 32'h7fff_ffff : {1'b0, wb_mag};
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_code_q <= res_code_q;
      out_cyc_q  <= res_cyc_q;
      out_pos_q  <= res_pos_q;
      out_vel_q  <= res_vel_q;
      out_fin_q  <= res_fin_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign phase_code_o      = out_code_q;
  assign cycle_number_o    = out_cyc_q;
  assign target_position_o = out_pos_q;
  assign target_velocity_o = out_vel_q;
  assign finished_o        = out_fin_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // a product only lands while the sequencer waits for it
  a_mul_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ews_pkg::ST_WAIT))
    else $error("multiplier finished outside the wait state");

  // a new output beat only comes from a finished tick
  a_out_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ews_pkg::ST_DONE))
    else $error("output beat raised without a finished tick");

  // the multiplier is only used for sine ticks of an armed run
  a_issue_sine : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ews_pkg::ST_ISSUE) |-> (cfg_mode_q && armed_q))
    else $error("product issued outside an armed sine tick");

endmodule

/* rtl/ews_serial_mul.sv */
// bit-serial signed multiplier, one multiplier bit per cycle
// widths from ews_pkg

module ews_serial_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ews_pkg::MUL_AW-1:0]   a_i,
  input  logic [ews_pkg::MUL_BW-1:0]   b_i,
  output logic                         done_o,
  output logic [ews_pkg::MUL_PW-1:0]   prod_o
);

  logic [ews_pkg::MUL_AW-1:0]    a_q;
  logic [ews_pkg::MUL_AW-1:0]    acc_q;
  logic [ews_pkg::MUL_BW-1:0]    b_q;
  logic [ews_pkg::MUL_CNT_W-1:0] cnt_q;
  logic                          busy_q;
  logic                          done_q;
  logic                          last;
  logic [ews_pkg::MUL_AW:0]      addend;
  logic [ews_pkg::MUL_AW:0]      sum;

  always_comb begin
    last   = (cnt_q == ews_pkg::MUL_CNT_W'(ews_pkg::MUL_BW - 1));
    addend = b_q[0] ? {a_q[ews_pkg::MUL_AW-1], a_q} : '0;
    // sign bit of b has negative weight
    if (last) begin
      sum = {acc_q[ews_pkg::MUL_AW-1], acc_q} - addend;
    end else begin
      sum = {acc_q[ews_pkg::MUL_AW-1], acc_q} + addend;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + ews_pkg::MUL_CNT_W'(1);
      if (last) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        done_q <= 1'b0;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      acc_q <= '0;
      b_q   <= b_i;
    end else if (busy_q) begin
      acc_q <= sum[ews_pkg::MUL_AW:1];
      b_q   <= {sum[0], b_q[ews_pkg::MUL_BW-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = {acc_q, b_q};

endmodule

/* test/ews_checker.sv */
`timescale 1ns / 100ps
// result checker for excitation_waveform_sequencer_core: watches the tick, result and
// register write channels, predicts every setpoint and compares it; depends on ews_pkg

module ews_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        restart_i,
  input  logic [31:0] baseline_position_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  phase_code_i,
  input  logic [7:0]  cycle_number_i,
  input  logic [31:0] target_position_i,
  input  logic [31:0] target_velocity_i,
  input  logic        finished_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          compared_o
);

  import ews_pkg::*;

  localparam longint     K_ONE_Q30    = 64'sd1073741824;
  localparam longint     K_HALF_PI    = 64'sd1686629713;
  localparam logic [63:0] K_TWO_PI_Q28 = 64'd1686629713;
  localparam logic [63:0] K_TICK_HZ    = 64'd1000;

  typedef struct packed {
    logic [1:0]  phase;
    logic [7:0]  cycle;
    logic [31:0] position;
    logic [31:0] velocity;
    logic        finished;
  } setpoint_t;

  setpoint_t setpoints_due[$];
  int        mismatches;
  int        compared;

  // register copy
  logic        sine_mode;
  logic [31:0] pre_len, act_len, post_len;
  logic [7:0]  rep_total;
  logic [31:0] step_off, amplitude, phase_step;

  // sequencer state
  logic        run_armed;
  logic [31:0] held_base, tick_count, accum;
  logic [7:0]  cycles_done;

  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic logic [31:0] sat_word(input longint x);
    if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  // taylor sine and cosine of a phase in turns / 2^32, reduced to the nearest quarter
  function automatic void sine_pair(input logic [31:0] ph, output longint s, output longint c);
    logic [31:0] shifted, resid;
    logic [1:0]  quad;
    longint      th, t2, hs, hc, ss, cc;
    shifted = ph + 32'h2000_0000;
    quad    = shifted[31:30];
    resid   = ph - {quad, 30'd0};
    th = (longint'($signed(resid)) * K_HALF_PI) >>> 30;
    t2 = qmul(th, th);
    hs = 2959;
    hs = 213044 - qmul(t2, hs);
    hs = 8947849 - qmul(t2, hs);
    hs = 178956971 - qmul(t2, hs);
    hs = K_ONE_Q30 - qmul(t2, hs);
    ss = qmul(th, hs);
    hc = 296;
    hc = 26631 - qmul(t2, hc);
    hc = 1491308 - qmul(t2, hc);
    hc = 44739243 - qmul(t2, hc);
    hc = 536870912 - qmul(t2, hc);
    cc = K_ONE_Q30 - qmul(t2, hc);
    case (quad)
      2'd0: begin s = ss; c = cc; end
      2'd1: begin s = cc; c = -ss; end
      2'd2: begin s = -ss; c = -cc; end
      default: begin s = -cc; c = ss; end
    endcase
  endfunction

  // desired velocity: |a*cos| scaled by 2*pi*f, saturated to 32 bits signed
  function automatic logic [31:0] sine_rate(input longint amp, input longint cs);
    longint       prod;
    logic         neg;
    logic [63:0]  m, k, w, mag;
    logic [127:0] scaled, wide;
    prod = amp * cs;
    neg  = (prod < 0);
    m    = neg ? 64'(-prod) : 64'(prod);
    m    = m >> 30;
    k    = 64'(phase_step) * K_TICK_HZ;
    scaled = {64'd0, k} * {64'd0, K_TWO_PI_Q28};
    w      = scaled[91:28];
    wide   = {64'd0, m} * {64'd0, w};
    if (wide[127:67] != '0) mag = 64'h8000_0000;
    else mag = wide[99:36];
    if (mag > 64'h8000_0000) mag = 64'h8000_0000;
    if (neg) return 32'(64'd0 - mag);
    return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  // advance the sequencer by one tick; returns 1 when the tick yields a setpoint
  function automatic bit predict_setpoint(input logic rs, input logic [31:0] base_in,
                                          output setpoint_t sp);
    longint      base, s, c, amp;
    logic [63:0] t, pre, act, total;
    logic [1:0]  ph;
    logic [31:0] pos, vel;
    sp = '0;
    if (rs) begin
      run_armed   = 1'b1;
      held_base   = base_in;
      tick_count  = '0;
      cycles_done = '0;
      accum       = '0;
    end
    if (!run_armed) return 1'b0;
    if (cycles_done >= rep_total) begin
      sp.phase    = PH_FIN;
      sp.cycle    = rep_total;
      sp.position = held_base;
      sp.finished = 1'b1;
      return 1'b1;
    end
    base  = longint'($signed(held_base));
    t     = 64'(tick_count);
    pre   = 64'(pre_len);
    act   = 64'(act_len);
    total = pre + act + 64'(post_len);
    pos   = held_base;
    vel   = '0;
    if (t < pre) begin
      ph = PH_PRE;
    end else if (t < pre + act) begin
      ph = PH_ACTIVE;
      if (!sine_mode) begin
        pos = sat_word(base + longint'($signed(step_off)));
      end else begin
        amp = longint'($signed(amplitude));
        sine_pair(accum, s, c);
        pos = sat_word(base + ((amp * s) >>> 30));
        vel = sine_rate(amp, c);
      end
      accum = accum + phase_step;
    end else begin
      ph = PH_POST;
    end
    if (ph != PH_ACTIVE) accum = '0;
    sp.cycle = cycles_done + 8'd1;
    if (t + 64'd1 >= total) begin
      tick_count  = '0;
      cycles_done = cycles_done + 8'd1;
      accum       = '0;
    end else begin
      tick_count = tick_count + 32'd1;
    end
    sp.phase    = ph;
    sp.position = pos;
    sp.velocity = vel;
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    setpoint_t want, pred;
    if (!rst_ni) begin
      sine_mode   = 1'b0;
      pre_len     = 32'd2000;
      act_len     = 32'd1000;
      post_len    = 32'd2000;
      rep_total   = 8'd3;
      step_off    = 32'd671089;
      amplitude   = 32'd536871;
      phase_step  = 32'd4294967;
      run_armed   = 1'b0;
      held_base   = '0;
      tick_count  = '0;
      cycles_done = '0;
      accum       = '0;
      mismatches  = 0;
      compared    = 0;
      setpoints_due.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      compared_o   <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (setpoints_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%t: result beat with nothing expected (phase %0d cycle %0d)",
                     $realtime, phase_code_i, cycle_number_i);
        end else begin
          want = setpoints_due.pop_front();
          compared++;
          if (want.phase !== phase_code_i || want.cycle !== cycle_number_i ||
              want.position !== target_position_i || want.velocity !== target_velocity_i ||
              want.finished !== finished_i) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%t: mismatch, expected/got phase %0d/%0d cycle %0d/%0d",
                       $realtime, want.phase, phase_code_i, want.cycle, cycle_number_i,
                       "\n  position %0d/%0d velocity %0d/%0d finished %0b/%0b",
                       $signed(want.position), $signed(target_position_i),
                       $signed(want.velocity), $signed(target_velocity_i),
                       want.finished, finished_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_EXCITE_MODE:     sine_mode  = cfg_data_i[0];
          CFG_PRE_HOLD_TICKS:  pre_len    = cfg_data_i;
          CFG_ACTIVE_TICKS:    act_len    = cfg_data_i;
          CFG_POST_HOLD_TICKS: post_len   = cfg_data_i;
          CFG_REPEAT_TOTAL:    rep_total  = cfg_data_i[7:0];
          CFG_STEP_SIZE:       step_off   = cfg_data_i;
          CFG_WAVE_AMPLITUDE:  amplitude  = cfg_data_i;
          CFG_PHASE_STEP:      phase_step = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (predict_setpoint(restart_i, baseline_position_i, pred))
          setpoints_due.push_back(pred);
      end
      fail_count_o <= mismatches;
      pending_o    <= setpoints_due.size();
      compared_o   <= compared;
    end
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// testbench top for excitation_waveform_sequencer_core: clock, reset, tick and register
// stimulus, result back-pressure and verdict; depends on ews_pkg and ews_checker

module tb_top;

  import ews_pkg::*;

  localparam int TARGET_TICKS = 1400;
  // covers any work in flight, a sine tick of the active phase included
  localparam int DRAIN_CYCLES = 600;
  // no handshake for this long means the block has hung
  localparam int STALL_LIMIT  = 20000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // tick channel
  logic        tick_valid   = 1'b0;
  logic        tick_stall;
  logic        tick_restart = 1'b0;
  logic [31:0] tick_base    = '0;
  // result channel
  logic        res_valid;
  logic        res_stall    = 1'b0;
  logic [1:0]  res_phase;
  logic [7:0]  res_cycle;
  logic [31:0] res_pos, res_vel;
  logic        res_fin;
  // register write channel
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index    = '0;
  logic [31:0] cfg_data     = '0;

  int fail_count, pending, compared;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned ticks_sent     = 0;
  int unsigned reg_writes     = 0;
  int unsigned phase_count    = 0;
  int unsigned quiet_cycles   = 0;

  always #5 clk_i = ~clk_i;

  excitation_waveform_sequencer_core u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (tick_valid),
    .in_stall_o          (tick_stall),
    .restart_i           (tick_restart),
    .baseline_position_i (tick_base),
    .out_valid_o         (res_valid),
    .out_stall_i         (res_stall),
    .phase_code_o        (res_phase),
    .cycle_number_o      (res_cycle),
    .target_position_o   (res_pos),
    .target_velocity_o   (res_vel),
    .finished_o          (res_fin),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data)
  );

  ews_checker u_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (tick_valid),
    .in_stall_i          (tick_stall),
    .restart_i           (tick_restart),
    .baseline_position_i (tick_base),
    .out_valid_i         (res_valid),
    .out_stall_i         (res_stall),
    .phase_code_i        (res_phase),
    .cycle_number_i      (res_cycle),
    .target_position_i   (res_pos),
    .target_velocity_i   (res_vel),
    .finished_i          (res_fin),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_i         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .fail_count_o        (fail_count),
    .pending_o           (pending),
    .compared_o          (compared)
  );

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk_i) begin
    res_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog on handshake progress of any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (tick_valid && !tick_stall) || (res_valid && !res_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%t: watchdog, no beat for %0d cycles, %0d results outstanding",
                 $realtime, STALL_LIMIT, pending);
        $display("excitation_waveform_sequencer_core verification failed");
        $finish;
      end
    end
  end

  // idling profile of a phase: none, sender gaps, receiver stalls, or a little of both
  task automatic set_idling(input int unsigned sel);
    case (sel % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
      default: begin send_idle_pct = 16; recv_stall_pct = 16; end
    endcase
  endtask

  // one tick beat; returns at the edge where it was taken, valid left high
  task automatic send_tick(input logic rs, input logic [31:0] base);
    while ($urandom_range(99) < send_idle_pct) begin
      tick_valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_valid   <= 1'b1;
    tick_restart <= rs;
    tick_base    <= base;
    @(posedge clk_i);
    while (tick_stall) @(posedge clk_i);
    ticks_sent++;
  endtask

  // register write beat; the caller drops cfg_valid after the last one
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    reg_writes++;
  endtask

  // wait for every expected setpoint, then let any result-less tick finish too
  task automatic settle();
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // tick lengths: mostly short so the run walks through its phases, now and then extreme
  function automatic logic [31:0] pick_len();
    int unsigned sel;
    sel = $urandom_range(15);
    if (sel == 0) return 32'hFFFF_FFFF;
    if (sel == 1) return $urandom;
    if (sel == 2) return 32'd0;
    return $urandom_range(1, 6);
  endfunction

  // signed q31.0 (integer) word with its extremes favoured
  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'd0;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    int unsigned n;
    logic [31:0] rep;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ticks before the first restart give no result
    set_idling(0);
    send_tick(1'b0, 32'h7FFF_FFFF);
    send_tick(1'b0, 32'h8000_0000);
    tick_valid <= 1'b0;
    settle();

    // step mode, one short cycle; the step pushes the target past positive full scale
    write_reg(CFG_EXCITE_MODE, 32'd0);
    write_reg(CFG_PRE_HOLD_TICKS, 32'd1);
    write_reg(CFG_ACTIVE_TICKS, 32'd2);
    write_reg(CFG_POST_HOLD_TICKS, 32'd1);
    write_reg(CFG_REPEAT_TOTAL, 32'd1);
    write_reg(CFG_STEP_SIZE, 32'h7FFF_FFFF);
    cfg_valid <= 1'b0;
    send_tick(1'b1, 32'h7FFF_FFFF);
    repeat (4) send_tick(1'b0, 32'h0);
    tick_valid <= 1'b0;
    set_idling(1);
    settle();

    // sine, quarter-turn phase steps visit every quadrant; most negative amplitude
    // drives the position to negative full scale and the velocity into saturation
    write_reg(CFG_EXCITE_MODE, 32'd1);
    write_reg(CFG_PRE_HOLD_TICKS, 32'd0);
    write_reg(CFG_ACTIVE_TICKS, 32'd4);
    write_reg(CFG_POST_HOLD_TICKS, 32'd0);
    write_reg(CFG_WAVE_AMPLITUDE, 32'h8000_0000);
    write_reg(CFG_PHASE_STEP, 32'h4000_0000);
    cfg_valid <= 1'b0;
    send_tick(1'b1, 32'h8000_0000);
    repeat (4) send_tick(1'b0, 32'h0);
    tick_valid <= 1'b0;
    set_idling(2);
    settle();

    // largest amplitude and phase step
    write_reg(CFG_ACTIVE_TICKS, 32'd2);
    write_reg(CFG_WAVE_AMPLITUDE, 32'h7FFF_FFFF);
    write_reg(CFG_PHASE_STEP, 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;
    send_tick(1'b1, 32'h7FFF_FFFF);
    send_tick(1'b0, 32'h0);
    tick_valid <= 1'b0;
    set_idling(3);
    settle();

    // no cycles at all: finished from the restart tick on
    write_reg(CFG_REPEAT_TOTAL, 32'd0);
    cfg_valid <= 1'b0;
    send_tick(1'b1, 32'h1234_5678);
    send_tick(1'b0, 32'h0);
    tick_valid <= 1'b0;
    settle();

    // zero-length cycles: every tick is a post-hold tick that closes a cycle
    write_reg(CFG_ACTIVE_TICKS, 32'd0);
    write_reg(CFG_REPEAT_TOTAL, 32'd3);
    cfg_valid <= 1'b0;
    send_tick(1'b1, 32'hFFFF_FFFF);
    repeat (3) send_tick(1'b0, 32'h0);
    tick_valid <= 1'b0;
    settle();

    // registers changed mid-run: the repeat count drops to the cycles already done
    write_reg(CFG_PRE_HOLD_TICKS, 32'd1);
    write_reg(CFG_ACTIVE_TICKS, 32'd1);
    write_reg(CFG_POST_HOLD_TICKS, 32'd1);
    write_reg(CFG_REPEAT_TOTAL, 32'd5);
    cfg_valid <= 1'b0;
    send_tick(1'b1, 32'h0000_0001);
    repeat (3) send_tick(1'b0, 32'h0);
    tick_valid <= 1'b0;
    settle();
    write_reg(CFG_REPEAT_TOTAL, 32'd1);
    cfg_valid <= 1'b0;
    repeat (2) send_tick(1'b0, 32'h0);
    tick_valid <= 1'b0;
    phase_count = 7;

    // random phases: fresh settings, then mostly a restart followed by a run of ticks;
    // runs carried over without restart exercise settings changed mid-run
    while (ticks_sent < TARGET_TICKS) begin
      settle();
      set_idling(phase_count);
      if ($urandom_range(1)) write_reg(CFG_EXCITE_MODE, $urandom);
      if ($urandom_range(1)) write_reg(CFG_PRE_HOLD_TICKS, pick_len());
      if ($urandom_range(1)) write_reg(CFG_ACTIVE_TICKS, pick_len());
      if ($urandom_range(1)) write_reg(CFG_POST_HOLD_TICKS, pick_len());
      if ($urandom_range(1)) begin
        case ($urandom_range(9))
          0: rep = 32'd255;
          1: rep = 32'($urandom_range(255));
          default: rep = 32'($urandom_range(4));
        endcase
        // upper bits beyond the 8-bit count are noise
        write_reg(CFG_REPEAT_TOTAL, (32'($urandom) & 32'hFFFF_FF00) | rep);
      end
      if ($urandom_range(1)) write_reg(CFG_STEP_SIZE, pick_word());
      if ($urandom_range(1)) write_reg(CFG_WAVE_AMPLITUDE, pick_word());
      if ($urandom_range(1)) begin
        case ($urandom_range(7))
          0: write_reg(CFG_PHASE_STEP, 32'd0);
          1: write_reg(CFG_PHASE_STEP, 32'hFFFF_FFFF);
          default: write_reg(CFG_PHASE_STEP, $urandom);
        endcase
      end
      cfg_valid <= 1'b0;
      n = $urandom_range(4, 30);
      send_tick($urandom_range(99) < 85, pick_word());
      repeat (n - 1) send_tick($urandom_range(99) < 3, pick_word());
      tick_valid <= 1'b0;
      phase_count++;
    end

    settle();
    $display("covered %0d tick beats over %0d setting phases with %0d register writes,",
             ticks_sent, phase_count, reg_writes);
    $display("  %0d setpoints compared across step, sine, hold and finished states", compared);
    if (fail_count == 0) begin
      $display("excitation_waveform_sequencer_core verification clean");
    end else begin
      $display("excitation_waveform_sequencer_core verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/ews_pkg.sv
rtl/ews_serial_mul.sv
rtl/excitation_waveform_sequencer_core.sv
test/ews_checker.sv
test/tb_top.sv
